/* rtl/fis_pkg.sv */
// Shared definitions for the fast reciprocal square root pipeline.
// Holds binary32 constants and the common round-and-pack function; no dependencies.
package fis_pkg;

    localparam logic [31:0] SEED_MAGIC = 32'h5F375A86;
    localparam logic [31:0] CANON_NAN  = 32'h7FC00000;
    localparam logic [31:0] FP_HALF    = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;

    // Rounds to nearest even and packs. e is the biased exponent of sig[23],
    // which may lie below one (subnormal result) or above the finite range.
    function automatic logic [31:0] fp_round(input logic sign, input logic signed [9:0] e,
                                             input logic [23:0] sig, input logic g,
                                             input logic st);
        logic [50:0] wide;
        logic [9:0]  sh;
        logic [23:0] s;
        logic        gg;
        logic        ss;
        logic [30:0] packed_v;
        logic        inc;
        wide = {sig, g, 26'd0};
        s = sig;
        gg = g;
        ss = st;
        packed_v = '0;
        if (e >= 10'sd255) begin
            fp_round = {sign, EXP_MAX, 23'd0};
        end else begin
            if (e < 10'sd1) begin
                sh = 10'd1 - $unsigned(e);
                if (sh > 10'd26) begin
                    sh = 10'd26;
                end
                wide = wide >> sh[4:0];
                s = wide[50:27];
                gg = wide[26];
                ss = st | (|wide[25:0]);
                packed_v = {7'd0, s};
            end else begin
                packed_v = {e[7:0] - 8'd1, 23'd0} + {7'd0, s};
            end
            inc = gg & (ss | s[0]);
            packed_v = packed_v + {30'd0, inc};
            fp_round = {sign, packed_v};
        end
    endfunction

endpackage

/* rtl/fis_fmul.sv */
// Three-stage binary32 multiplier: unpack and normalise, multiply, round.
// Depends on fis_pkg for the rounding function and constants.
module fis_fmul import fis_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic        sa, sb_s, za, zb, ia, ib, na, nb;
    logic [23:0] ma_next, mb_next;
    logic signed [9:0] ea_next, eb_next;

    // Stage 1 registers
    logic        sign1_reg, nan1_reg, inf1_reg, zero1_reg;
    logic [23:0] ma1_reg, mb1_reg;
    logic signed [9:0] ea1_reg, eb1_reg;
    // Stage 2 registers
    logic        sign2_reg, nan2_reg, inf2_reg, zero2_reg;
    logic [47:0] p2_reg;
    logic signed [9:0] e2_reg;
    logic [31:0] y_reg, y_next;

    function automatic logic [4:0] lzc24(input logic [23:0] m);
        logic [4:0] z;
        z = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (m[i]) begin
                z = 5'(23 - i);
            end
        end
        lzc24 = z;
    endfunction

    function automatic logic [33:0] unpack(input logic [31:0] v);
        logic [23:0] m;
        logic [4:0]  z;
        logic signed [9:0] e;
        m = {v[30:23] != 8'd0, v[22:0]};
        z = lzc24(m);
        if (z == 5'd24) begin
            z = 5'd0;
        end
        e = $signed({2'b00, (v[30:23] == 8'd0) ? 8'd1 : v[30:23]}) - $signed({5'd0, z});
        unpack = {e, m << z};
    endfunction

    always_comb begin
        sa = a[31];
        sb_s = b[31];
        za = (a[30:0] == 31'd0);
        zb = (b[30:0] == 31'd0);
        ia = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        ib = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        na = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nb = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        {ea_next, ma_next} = unpack(a);
        {eb_next, mb_next} = unpack(b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sign1_reg <= sa ^ sb_s;
            nan1_reg  <= na | nb | (ia & zb) | (za & ib);
            inf1_reg  <= ia | ib;
            zero1_reg <= za | zb;
            ma1_reg   <= ma_next;
            mb1_reg   <= mb_next;
            ea1_reg   <= ea_next;
            eb1_reg   <= eb_next;

            sign2_reg <= sign1_reg;
            nan2_reg  <= nan1_reg;
            inf2_reg  <= inf1_reg;
            zero2_reg <= zero1_reg;
            p2_reg    <= ma1_reg * mb1_reg;
            e2_reg    <= ea1_reg + eb1_reg - 10'sd127;

            y_reg     <= y_next;
        end
    end

    always_comb begin
        if (nan2_reg) begin
            y_next = CANON_NAN;
        end else if (inf2_reg) begin
            y_next = {sign2_reg, EXP_MAX, 23'd0};
        end else if (zero2_reg) begin
            y_next = {sign2_reg, 31'd0};
        end else if (p2_reg[47]) begin
            y_next = fp_round(sign2_reg, e2_reg + 10'sd1, p2_reg[47:24], p2_reg[23],
                              |p2_reg[22:0]);
        end else begin
            y_next = fp_round(sign2_reg, e2_reg, p2_reg[46:23], p2_reg[22], |p2_reg[21:0]);
        end
    end

    assign y = y_reg;

endmodule

/* rtl/fis_fsub.sv */
// Four-stage binary32 subtractor y = a - b: align, add, normalise, round.
// Depends on fis_pkg for the rounding function and constants.
module fis_fsub import fis_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    logic [31:0] bn, xv, yv;
    logic        ia, ib, na, nb;
    logic [7:0]  ex, ey, d;
    logic [26:0] ywide, yal;
    logic        yst;

    logic        sx1_reg, sub1_reg, nan1_reg, inf1_reg, infs1_reg;
    logic [26:0] x1_reg, y1_reg;
    logic [7:0]  ex1_reg;
    logic        sx2_reg, sub2_reg, nan2_reg, inf2_reg, infs2_reg;
    logic [27:0] sum2_reg;
    logic [7:0]  ex2_reg;
    logic        sx3_reg, zs3_reg, zero3_reg, nan3_reg, inf3_reg, infs3_reg;
    logic [26:0] n3_reg, n_next;
    logic signed [9:0] e3_reg, e_next;
    logic [31:0] y_reg, y_next;
    logic [4:0]  lz;
    logic [7:0]  sh;

    always_comb begin
        bn = {~b[31], b[30:0]};
        ia = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        ib = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        na = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nb = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        if (a[30:0] >= bn[30:0]) begin
            xv = a;
            yv = bn;
        end else begin
            xv = bn;
            yv = a;
        end
        ex = (xv[30:23] == 8'd0) ? 8'd1 : xv[30:23];
        ey = (yv[30:23] == 8'd0) ? 8'd1 : yv[30:23];
        d = ex - ey;
        ywide = {yv[30:23] != 8'd0, yv[22:0], 3'd0};
        if (d >= 8'd27) begin
            yal = '0;
            yst = (ywide != 27'd0);
        end else begin
            yal = ywide >> d[4:0];
            yst = ((ywide & ((27'd1 << d[4:0]) - 27'd1)) != 27'd0);
        end
        yal[0] = yal[0] | yst;
    end

    always_comb begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (sum2_reg[i]) begin
                lz = 5'(26 - i);
            end
        end
        if ({3'd0, lz} > ex2_reg - 8'd1) begin
            sh = ex2_reg - 8'd1;
        end else begin
            sh = {3'd0, lz};
        end
        if (sum2_reg[27]) begin
            n_next = {sum2_reg[27:2], sum2_reg[1] | sum2_reg[0]};
            e_next = $signed({2'b00, ex2_reg}) + 10'sd1;
        end else begin
            n_next = sum2_reg[26:0] << sh[4:0];
            e_next = $signed({2'b00, ex2_reg}) - $signed({2'b00, sh});
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx1_reg   <= xv[31];
            sub1_reg  <= xv[31] ^ yv[31];
            nan1_reg  <= na | nb | (ia & ib & (a[31] == b[31]));
            inf1_reg  <= ia | ib;
            infs1_reg <= ia ? a[31] : ~b[31];
            x1_reg    <= {xv[30:23] != 8'd0, xv[22:0], 3'd0};
            y1_reg    <= yal;
            ex1_reg   <= ex;

            sx2_reg   <= sx1_reg;
            sub2_reg  <= sub1_reg;
            nan2_reg  <= nan1_reg;
            inf2_reg  <= inf1_reg;
            infs2_reg <= infs1_reg;
            sum2_reg  <= sub1_reg ? ({1'b0, x1_reg} - {1'b0, y1_reg})
                                  : ({1'b0, x1_reg} + {1'b0, y1_reg});
            ex2_reg   <= ex1_reg;

            sx3_reg   <= sx2_reg;
            zs3_reg   <= sub2_reg ? 1'b0 : sx2_reg;
            zero3_reg <= (sum2_reg == 28'd0);
            nan3_reg  <= nan2_reg;
            inf3_reg  <= inf2_reg;
            infs3_reg <= infs2_reg;
            n3_reg    <= n_next;
            e3_reg    <= e_next;

            y_reg     <= y_next;
        end
    end

    always_comb begin
        if (nan3_reg) begin
            y_next = CANON_NAN;
        end else if (inf3_reg) begin
            y_next = {infs3_reg, EXP_MAX, 23'd0};
        end else if (zero3_reg) begin
            y_next = {zs3_reg, 31'd0};
        end else begin
            y_next = fp_round(sx3_reg, e3_reg, n3_reg[26:3], n3_reg[2], |n3_reg[1:0]);
        end
    end

    assign y = y_reg;

endmodule

/* rtl/fast_inverse_sqrt_fp32_top.sv */
// Fast reciprocal square root of a binary32 operand with one Newton step.
// Depends on fis_pkg, fis_fmul and fis_fsub.
//
// Usage: a request on the s_ channel carries a raw binary32 operand in
// s_operand_bits; the m_ channel returns the approximation of 1/sqrt(x) in
// m_result_bits, one result per request, in request order.
// Each request passes through half and the squared seed in parallel, then
// their product, then the subtraction from 1.5 and then the final multiply.
// Throughput is one request per cycle while the receiver does not stall;
// the pipeline holds up to 13 requests.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and s_ready falls, so nothing is lost or repeated; a pipeline with no
// waiting result keeps accepting.
// Reset clears only the valid bits; the data registers are not reset.
// Every NaN result is returned as the canonical quiet NaN 0x7FC00000.
module fast_inverse_sqrt_fp32_top import fis_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_operand_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_bits
);

    localparam int DEPTH = 13;
    localparam int SEED_DELAY = 10;

    logic             en;
    logic [DEPTH-1:0] vld_reg;
    logic [31:0]      seed;
    logic [31:0]      half, sq, prod, diff;
    logic [31:0]      seed_dly_reg [SEED_DELAY];

    assign en = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = en;
    assign seed = SEED_MAGIC - {1'b0, s_operand_bits[31:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // The seed must meet the Newton correction term after ten stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            seed_dly_reg[0] <= seed;
            for (int i = 1; i < SEED_DELAY; i++) begin
                seed_dly_reg[i] <= seed_dly_reg[i-1];
            end
        end
    end

    fis_fmul u_half (.aclk(aclk), .en(en), .a(s_operand_bits), .b(FP_HALF), .y(half));
    fis_fmul u_sq   (.aclk(aclk), .en(en), .a(seed), .b(seed), .y(sq));
    fis_fmul u_prod (.aclk(aclk), .en(en), .a(half), .b(sq), .y(prod));
    fis_fsub u_diff (.aclk(aclk), .en(en), .a(FP_THREE_HALVES), .b(prod), .y(diff));
    fis_fmul u_res  (.aclk(aclk), .en(en), .a(seed_dly_reg[SEED_DELAY-1]), .b(diff),
                     .y(m_result_bits));

    assign m_valid = vld_reg[DEPTH-1];

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid bits survive reset");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_bits)))
        else $error("stalled result changed");
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("request accepted while pipeline frozen");
    a_nan_canon: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_bits[30:23] == EXP_MAX && m_result_bits[22:0] != 23'd0)
        |-> (m_result_bits == CANON_NAN))
        else $error("non-canonical NaN on output");

endmodule
